FILE: rtl/urb_pkg.sv
// Types and constants shared by the UART register block.
`default_nettype none
package urb_pkg;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;

    localparam logic [31:0] OFS_TX   = 32'd4;
    localparam logic [31:0] OFS_STAT = 32'd8;
    localparam logic [31:0] OFS_CTRL = 32'd12;

    localparam logic [7:0] STAT_TX_READY = 8'h40;

    localparam int unsigned TX_IE_BIT = 6;
    localparam int unsigned RX_IE_BIT = 7;

    localparam logic [7:0] CFG_BASE_ADDRESS  = 8'd0;
    localparam logic [7:0] CFG_IRQ_CONNECTED = 8'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
        logic [7:0]  write_data;
        logic [7:0]  rx_char;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_char;
        logic       irq_level;
        logic       rx_dropped;
    } result_t;

    // Per-cell control of the receive queue chain
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/urb_cell.sv
// One storage cell of the receive queue chain.
`default_nettype none
module urb_cell
    import urb_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic [7:0] din,
    input  wire logic [7:0] right,
    output logic [7:0]      q
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    // Load a new character, or take the neighbour's one on a pop
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = din;
        end
        else if (ctrl.shift)
        begin
            data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule
`default_nettype wire

FILE: rtl/uart_register_block_unit.sv
// Top level of the memory-mapped UART register block.
//
//  channel | signals                          | direction
//  in      | in_valid, in_ready, in_item      | bus access or received character
//  out     | out_valid, out_ready, out_item   | one result per transaction
//  cfg     | cfg_valid, cfg_ready, cfg_index, | register write, always ready
//          | cfg_data                         |
//
// One transaction per cycle while in_ready is high; each result is registered.
// The receive queue is a chain of cells: cell 0 is the oldest character and a
// pop moves every cell one step towards it on the same clock edge.
// A two-deep output stage (output register plus skid) keeps in_ready off out_ready.
// Reset clears control state and the queue count; cell contents are not reset.
`default_nettype none
module uart_register_block_unit
    import urb_pkg::*;
#(
    parameter int unsigned RX_FIFO_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire item_t       in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output result_t          out_item,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int unsigned CNT_W = $clog2(RX_FIFO_DEPTH + 1);

    logic [31:0]      base_reg;
    logic [31:0]      base_next;
    logic             irq_conn_reg;
    logic             irq_conn_next;
    logic [7:0]       holding_reg;
    logic [7:0]       holding_next;
    logic             ready_reg;
    logic             ready_next;
    logic             tx_ie_reg;
    logic             tx_ie_next;
    logic             rx_ie_reg;
    logic             rx_ie_next;
    logic             irq_reg;
    logic             irq_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    result_t out_reg;
    result_t out_next;
    result_t skid_reg;
    result_t skid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;

    logic    accept;
    logic    push;
    logic    pop;
    result_t res;

    logic [7:0] cell_q [RX_FIFO_DEPTH];

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Configuration registers
    always_comb
    begin
        base_next     = base_reg;
        irq_conn_next = irq_conn_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BASE_ADDRESS:  base_next = cfg_data;
                CFG_IRQ_CONNECTED: irq_conn_next = cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Register decode and receive-path state update
    always_comb
    begin
        holding_next = holding_reg;
        ready_next   = ready_reg;
        tx_ie_next   = tx_ie_reg;
        rx_ie_next   = rx_ie_reg;
        irq_next     = irq_reg;
        count_next   = count_reg;
        push         = 1'b0;
        pop          = 1'b0;
        res          = '0;
        if (accept)
        begin
            case (in_item.mode)
                MODE_READ:
                begin
                    if (in_item.address == base_reg)
                    begin
                        res.read_data = holding_reg;
                        if (count_reg != '0)
                        begin
                            holding_next = cell_q[0];
                            ready_next   = 1'b1;
                            pop          = 1'b1;
                            count_next   = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            holding_next = '0;
                            ready_next   = 1'b0;
                            if (rx_ie_reg && irq_conn_reg)
                            begin
                                irq_next = 1'b0;
                            end
                        end
                    end
                    else if (in_item.address == base_reg + OFS_STAT)
                    begin
                        res.read_data = STAT_TX_READY | {ready_reg, 7'd0};
                    end
                    else if (in_item.address == base_reg + OFS_CTRL)
                    begin
                        res.read_data = '0;
                        res.read_data[TX_IE_BIT] = tx_ie_reg;
                        res.read_data[RX_IE_BIT] = rx_ie_reg;
                    end
                end
                MODE_WRITE:
                begin
                    if (in_item.address == base_reg + OFS_TX)
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_char  = in_item.write_data;
                        if (tx_ie_reg && irq_conn_reg)
                        begin
                            irq_next = 1'b0;
                        end
                    end
                    else if (in_item.address == base_reg + OFS_CTRL)
                    begin
                        tx_ie_next = in_item.write_data[TX_IE_BIT];
                        rx_ie_next = in_item.write_data[RX_IE_BIT];
                        if (irq_conn_reg)
                        begin
                            irq_next = in_item.write_data[TX_IE_BIT];
                        end
                    end
                end
                MODE_RX:
                begin
                    if (!ready_reg)
                    begin
                        holding_next = in_item.rx_char;
                        ready_next   = 1'b1;
                    end
                    else if (count_reg != CNT_W'(RX_FIFO_DEPTH))
                    begin
                        push       = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res.rx_dropped = 1'b1;
                    end
                    if (rx_ie_reg && irq_conn_reg)
                    begin
                        irq_next = 1'b1;
                    end
                end
                default: ;
            endcase
            res.irq_level = irq_next & irq_conn_reg;
        end
    end

    // Receive queue: a chain of cells, cell 0 holds the oldest character
    for (genvar i = 0; i < RX_FIFO_DEPTH; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        logic [7:0] right;

        assign ctrl.load  = push && (count_reg == CNT_W'(i));
        assign ctrl.shift = pop;

        if (i == RX_FIFO_DEPTH - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_mid
            assign right = cell_q[i+1];
        end

        urb_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .din   (in_item.rx_char),
            .right (right),
            .q     (cell_q[i])
        );
    end

    // Output register with skid stage
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            irq_conn_reg   <= 1'b0;
            holding_reg    <= '0;
            ready_reg      <= 1'b0;
            tx_ie_reg      <= 1'b0;
            rx_ie_reg      <= 1'b0;
            irq_reg        <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg       <= base_next;
            irq_conn_reg   <= irq_conn_next;
            holding_reg    <= holding_next;
            ready_reg      <= ready_next;
            tx_ie_reg      <= tx_ie_next;
            rx_ie_reg      <= rx_ie_next;
            irq_reg        <= irq_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RX_FIFO_DEPTH))
        else $error("receive queue count beyond depth");

    a_queue_needs_holding: assert property (@(posedge clk) disable iff (!rst_n)
        !ready_reg |-> count_reg == '0)
        else $error("characters queued while holding register empty");

    a_full_drop_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_item.mode == MODE_RX && ready_reg
        && count_reg == CNT_W'(RX_FIFO_DEPTH) |=> count_reg == CNT_W'(RX_FIFO_DEPTH))
        else $error("full queue changed on a dropped character");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while output register is empty");
`endif

endmodule
`default_nettype wire
